FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define CQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define CQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cqcp_pkg.sv
// ----------------------------------------------------------------------------
// cqcp_pkg
// Shared constants, types and helpers of the circle/quad collision pipeline.
// ----------------------------------------------------------------------------
package cqcp_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // Stage advance and item valid travel together into the iterative units.
  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

  // Register stages of one edge unit: four setup stages, one per quotient
  // bit of t, then scale, subtract, square and sum.
  function automatic int edge_latency(input int frac_bits);
    return frac_bits + 8;
  endfunction

endpackage

FILE: hdl/cqcp_edge.sv
// ----------------------------------------------------------------------------
// cqcp_edge
// Closest-point vector from one wall edge to the circle center, and its
// squared length.
// ----------------------------------------------------------------------------
module cqcp_edge #(
  parameter int COORD_WIDTH = cqcp_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = cqcp_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  output logic signed [COORD_WIDTH+2:0] vec_x,
  output logic signed [COORD_WIDTH+2:0] vec_y,
  output logic        [2*COORD_WIDTH+5:0] dist2
);

  localparam int DW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 1;
  localparam int VW  = DW + 2;
  localparam int QW  = 2 * VW;
  localparam int TW  = FRAC_BITS + 1;
  localparam int LTW = DW + TW + 1;

  logic signed [DW-1:0] lx1_r, ly1_r, px1_r, py1_r;
  logic signed [PW-1:0] pxlx_r, pyly_r, lxlx_r, lyly_r;
  logic signed [DW-1:0] lx2_r, ly2_r, px2_r, py2_r;
  logic signed [SW-1:0] dot_r, len2_r;
  logic signed [DW-1:0] lx3_r, ly3_r, px3_r, py3_r;
  logic                 zero4_r, one4_r;
  logic        [SW-1:0] rem4_r, len4_r;
  logic signed [DW-1:0] lx4_r, ly4_r, px4_r, py4_r;

  logic        [SW-1:0]        drem_r [FRAC_BITS];
  logic        [SW-1:0]        dlen_r [FRAC_BITS];
  logic        [FRAC_BITS-1:0] dq_r   [FRAC_BITS];
  logic                        dzero_r[FRAC_BITS];
  logic                        done_r [FRAC_BITS];
  logic signed [DW-1:0]        dlx_r  [FRAC_BITS];
  logic signed [DW-1:0]        dly_r  [FRAC_BITS];
  logic signed [DW-1:0]        dpx_r  [FRAC_BITS];
  logic signed [DW-1:0]        dpy_r  [FRAC_BITS];

  logic        [TW-1:0]  t_w;
  logic signed [LTW-1:0] ltx_r, lty_r;
  logic signed [DW-1:0]  pxm_r, pym_r;
  logic signed [VW-1:0]  vx_r, vy_r;
  logic signed [QW-1:0]  sqx_r, sqy_r;
  logic signed [VW-1:0]  vxs_r, vys_r;
  logic        [QW-1:0]  d2_r;
  logic signed [VW-1:0]  vxd_r, vyd_r;

  // edge vector and center offset
  always_ff @(posedge clk) begin
    if (en) begin
      lx1_r <= DW'(end_x) - DW'(start_x);
      ly1_r <= DW'(end_y) - DW'(start_y);
      px1_r <= DW'(center_x) - DW'(start_x);
      py1_r <= DW'(center_y) - DW'(start_y);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxlx_r <= PW'(px1_r) * PW'(lx1_r);
      pyly_r <= PW'(py1_r) * PW'(ly1_r);
      lxlx_r <= PW'(lx1_r) * PW'(lx1_r);
      lyly_r <= PW'(ly1_r) * PW'(ly1_r);
      lx2_r  <= lx1_r;
      ly2_r  <= ly1_r;
      px2_r  <= px1_r;
      py2_r  <= py1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot_r  <= SW'(pxlx_r) + SW'(pyly_r);
      len2_r <= SW'(lxlx_r) + SW'(lyly_r);
      lx3_r  <= lx2_r;
      ly3_r  <= ly2_r;
      px3_r  <= px2_r;
      py3_r  <= py2_r;
    end
  end

  // clamp decisions; the quotient is only used strictly inside (0, len2)
  always_ff @(posedge clk) begin
    if (en) begin
      zero4_r <= (dot_r <= 0);
      one4_r  <= (dot_r >= len2_r);
      rem4_r  <= unsigned'(dot_r);
      len4_r  <= unsigned'(len2_r);
      lx4_r   <= lx3_r;
      ly4_r   <= ly3_r;
      px4_r   <= px3_r;
      py4_r   <= py3_r;
    end
  end

  // one quotient bit of t per stage
  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
    logic        [SW-1:0]        rem_i, len_i, sh_w;
    logic        [FRAC_BITS-1:0] q_i;
    logic                        zero_i, one_i, ge_w;
    logic signed [DW-1:0]        lx_i, ly_i, px_i, py_i;

    if (k == 0) begin : g_first
      assign rem_i  = rem4_r;
      assign len_i  = len4_r;
      assign q_i    = '0;
      assign zero_i = zero4_r;
      assign one_i  = one4_r;
      assign lx_i   = lx4_r;
      assign ly_i   = ly4_r;
      assign px_i   = px4_r;
      assign py_i   = py4_r;
    end else begin : g_next
      assign rem_i  = drem_r[k-1];
      assign len_i  = dlen_r[k-1];
      assign q_i    = dq_r[k-1];
      assign zero_i = dzero_r[k-1];
      assign one_i  = done_r[k-1];
      assign lx_i   = dlx_r[k-1];
      assign ly_i   = dly_r[k-1];
      assign px_i   = dpx_r[k-1];
      assign py_i   = dpy_r[k-1];
    end

    assign sh_w = {rem_i[SW-2:0], 1'b0};
    assign ge_w = (sh_w >= len_i);

    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[k]  <= ge_w ? (sh_w - len_i) : sh_w;
        dlen_r[k]  <= len_i;
        dq_r[k]    <= {q_i[FRAC_BITS-2:0], ge_w};
        dzero_r[k] <= zero_i;
        done_r[k]  <= one_i;
        dlx_r[k]   <= lx_i;
        dly_r[k]   <= ly_i;
        dpx_r[k]   <= px_i;
        dpy_r[k]   <= py_i;
      end
    end
  end

  always_comb begin
    if (dzero_r[FRAC_BITS-1]) begin
      t_w = '0;
    end else if (done_r[FRAC_BITS-1]) begin
      t_w = {1'b1, {FRAC_BITS{1'b0}}};
    end else begin
      t_w = {1'b0, dq_r[FRAC_BITS-1]};
    end
  end

  // scale the edge by t
  always_ff @(posedge clk) begin
    if (en) begin
      ltx_r <= LTW'(dlx_r[FRAC_BITS-1]) * LTW'($signed({1'b0, t_w}));
      lty_r <= LTW'(dly_r[FRAC_BITS-1]) * LTW'($signed({1'b0, t_w}));
      pxm_r <= dpx_r[FRAC_BITS-1];
      pym_r <= dpy_r[FRAC_BITS-1];
    end
  end

  // arithmetic shift floors toward minus infinity
  always_ff @(posedge clk) begin
    if (en) begin
      vx_r <= VW'(pxm_r) - VW'(ltx_r >>> FRAC_BITS);
      vy_r <= VW'(pym_r) - VW'(lty_r >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r <= QW'(vx_r) * QW'(vx_r);
      sqy_r <= QW'(vy_r) * QW'(vy_r);
      vxs_r <= vx_r;
      vys_r <= vy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_r  <= unsigned'(sqx_r) + unsigned'(sqy_r);
      vxd_r <= vxs_r;
      vyd_r <= vys_r;
    end
  end

  assign vec_x = vxd_r;
  assign vec_y = vyd_r;
  assign dist2 = d2_r;

endmodule

FILE: hdl/cqcp_sqrt.sv
// ----------------------------------------------------------------------------
// cqcp_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module cqcp_sqrt #(
  parameter int NW  = 2 * (cqcp_pkg::COORD_WIDTH_DEF + 3),
  parameter int SBW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cqcp_pkg::pipe_ctl_t ctl,
  input  logic [NW-1:0]       radicand,
  input  logic [SBW-1:0]      side_i,
  output logic                vld_o,
  output logic [NW/2-1:0]     root_o,
  output logic [SBW-1:0]      side_o
);

  localparam int RW = NW / 2;

  logic [RW:0]    rem_r  [RW];
  logic [RW-1:0]  root_r [RW];
  logic [NW-1:0]  n_r    [RW];
  logic [SBW-1:0] side_r [RW];
  logic           vld_r  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_st
    logic [RW:0]    rem_i;
    logic [RW-1:0]  root_i;
    logic [NW-1:0]  n_i;
    logic [SBW-1:0] side_v;
    logic           vld_i, ge_w;
    logic [RW+2:0]  nrem_w, trial_w;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign n_i    = radicand;
      assign side_v = side_i;
      assign vld_i  = ctl.vld;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign n_i    = n_r[k-1];
      assign side_v = side_r[k-1];
      assign vld_i  = vld_r[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign nrem_w  = {rem_i, n_i[NW-1:NW-2]};
    assign trial_w = {1'b0, root_i, 2'b01};
    assign ge_w    = (nrem_w >= trial_w);

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem_r[k]  <= ge_w ? (RW+1)'(nrem_w - trial_w) : (RW+1)'(nrem_w);
        root_r[k] <= {root_i[RW-2:0], ge_w};
        n_r[k]    <= {n_i[NW-3:0], 2'b00};
        side_r[k] <= side_v;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ctl.en) begin
        vld_r[k] <= vld_i;
      end
    end
  end

  assign vld_o  = vld_r[RW-1];
  assign root_o = root_r[RW-1];
  assign side_o = side_r[RW-1];

endmodule

FILE: hdl/cqcp_div.sv
// ----------------------------------------------------------------------------
// cqcp_div
// Pipelined restoring divider, one quotient bit per stage. The quotient must
// fit QB bits.
// ----------------------------------------------------------------------------
module cqcp_div #(
  parameter int NW  = 2 * cqcp_pkg::COORD_WIDTH_DEF + 2,
  parameter int DVW = cqcp_pkg::COORD_WIDTH_DEF + 3,
  parameter int QB  = cqcp_pkg::COORD_WIDTH_DEF,
  parameter int SBW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cqcp_pkg::pipe_ctl_t ctl,
  input  logic [NW-1:0]       num,
  input  logic [DVW-1:0]      den,
  input  logic [SBW-1:0]      side_i,
  output logic                vld_o,
  output logic [QB-1:0]       quo,
  output logic [SBW-1:0]      side_o
);

  logic [DVW-1:0] rem_r  [QB];
  logic [DVW-1:0] den_r  [QB];
  logic [QB-1:0]  lo_r   [QB];
  logic [QB-1:0]  q_r    [QB];
  logic [SBW-1:0] side_r [QB];
  logic           vld_r  [QB];

  for (genvar k = 0; k < QB; k++) begin : g_st
    logic [DVW-1:0] rem_i, den_i;
    logic [QB-1:0]  lo_i, q_i;
    logic [SBW-1:0] side_v;
    logic           vld_i, ge_w;
    logic [DVW:0]   sh_w, diff_w;

    if (k == 0) begin : g_first
      // high part of the numerator is already below the divisor
      assign rem_i  = DVW'(num >> QB);
      assign den_i  = den;
      assign lo_i   = num[QB-1:0];
      assign q_i    = '0;
      assign side_v = side_i;
      assign vld_i  = ctl.vld;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign den_i  = den_r[k-1];
      assign lo_i   = lo_r[k-1];
      assign q_i    = q_r[k-1];
      assign side_v = side_r[k-1];
      assign vld_i  = vld_r[k-1];
    end

    assign sh_w   = {rem_i, lo_i[QB-1]};
    assign diff_w = sh_w - {1'b0, den_i};
    assign ge_w   = (sh_w >= {1'b0, den_i});

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem_r[k]  <= ge_w ? DVW'(diff_w) : DVW'(sh_w);
        den_r[k]  <= den_i;
        lo_r[k]   <= lo_i << 1;
        q_r[k]    <= {q_i[QB-2:0], ge_w};
        side_r[k] <= side_v;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ctl.en) begin
        vld_r[k] <= vld_i;
      end
    end
  end

  assign vld_o  = vld_r[QB-1];
  assign quo    = q_r[QB-1];
  assign side_o = side_r[QB-1];

endmodule

FILE: hdl/circle_quad_collision_push.sv
// ----------------------------------------------------------------------------
// circle_quad_collision_push
// Circle against quadrilateral wall: nearest-edge distance, hit flag and
// saturated push-out vector, fully pipelined.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Ports               Payload (lowest bit first)
//  -------  ---  ------------------  ----------------------------------------
//  in_      in   tvalid/tready/tdata center_x, center_y, radius, top_left_x/y,
//                                    top_right_x/y, bottom_right_x/y,
//                                    bottom_left_x/y, zero pad to bytes
//  out_     out  tvalid/tready/tdata hit, push_x, push_y, zero pad to bytes
//
//  One transaction per cycle in and out while out_ is not stalled.
//  Most of the pipeline depth is set by the bit-serial t quotient,
//  the square root (one bit per stage) and the push divider (one bit
//  per stage).
//  A stall on out_ freezes every stage at once; in_tready follows it.
//  rst_n clears all valid bits; data registers are not reset.
//
module circle_quad_collision_push #(
  parameter int COORD_WIDTH = cqcp_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = cqcp_pkg::FRAC_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  // center_x, center_y, radius, top_left_x, top_left_y, top_right_x,
  // top_right_y, bottom_right_x, bottom_right_y, bottom_left_x, bottom_left_y
  input  logic [((11*COORD_WIDTH-1+7)/8)*8-1:0]         in_tdata,
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  // hit, push_x, push_y
  output logic [((2*COORD_WIDTH+1+7)/8)*8-1:0]          out_tdata
);

  localparam int CW     = COORD_WIDTH;
  localparam int RADW   = CW - 1;
  localparam int VW     = CW + 3;
  localparam int QW     = 2 * VW;
  localparam int EL     = cqcp_pkg::edge_latency(FRAC_BITS);
  localparam int OUT_W  = ((2*CW+1+7)/8)*8;
  localparam int NW     = VW + RADW;
  localparam int SQ_SBW = 2 * VW + RADW;
  localparam int DX_SBW = 3;
  localparam logic [CW-1:0] MAXMAG = {1'b0, {(CW-1){1'b1}}};

  logic adv;
  logic out_tvalid_r;

  // Whole pipe advances unless a finished result is waiting.
  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;

  // ---- unpack the query
  logic signed [CW-1:0]   cx_w, cy_w;
  logic        [RADW-1:0] rad_w;
  logic signed [CW-1:0]   kx_w [4];
  logic signed [CW-1:0]   ky_w [4];

  assign cx_w  = in_tdata[CW-1:0];
  assign cy_w  = in_tdata[2*CW-1:CW];
  assign rad_w = in_tdata[3*CW-2:2*CW];

  for (genvar i = 0; i < 4; i++) begin : g_corner
    assign kx_w[i] = in_tdata[3*CW-1 + 2*i*CW +: CW];
    assign ky_w[i] = in_tdata[3*CW-1 + 2*i*CW + CW +: CW];
  end

  // ---- four edges: top, right, bottom, left
  logic signed [VW-1:0] evx_w [4];
  logic signed [VW-1:0] evy_w [4];
  logic        [QW-1:0] ed2_w [4];

  for (genvar e = 0; e < 4; e++) begin : g_edge
    cqcp_edge #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_edge (
      .clk      (clk),
      .en       (adv),
      .start_x  (kx_w[e]),
      .start_y  (ky_w[e]),
      .end_x    (kx_w[(e+1)%4]),
      .end_y    (ky_w[(e+1)%4]),
      .center_x (cx_w),
      .center_y (cy_w),
      .vec_x    (evx_w[e]),
      .vec_y    (evy_w[e]),
      .dist2    (ed2_w[e])
    );
  end

  // ---- valid and radius ride alongside the edge units
  logic            vline_r [EL];
  logic [RADW-1:0] rline_r [EL];

  for (genvar k = 0; k < EL; k++) begin : g_line
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vline_r[k] <= 1'b0;
        end else if (adv) begin
          vline_r[k] <= in_tvalid;
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          rline_r[k] <= rad_w;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vline_r[k] <= 1'b0;
        end else if (adv) begin
          vline_r[k] <= vline_r[k-1];
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          rline_r[k] <= rline_r[k-1];
        end
      end
    end
  end

  // ---- nearest edge; the later edge wins only when strictly closer
  logic                 av_r, bv_r;
  logic        [QW-1:0] a0_d2_r, a1_d2_r, b_d2_r;
  logic signed [VW-1:0] a0_vx_r, a0_vy_r, a1_vx_r, a1_vy_r, b_vx_r, b_vy_r;
  logic      [RADW-1:0] ar_r, br_r;
  logic                 p1_w, p3_w, pb_w;

  assign p1_w = ed2_w[1] < ed2_w[0];
  assign p3_w = ed2_w[3] < ed2_w[2];
  assign pb_w = a1_d2_r < a0_d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      av_r <= 1'b0;
      bv_r <= 1'b0;
    end else if (adv) begin
      av_r <= vline_r[EL-1];
      bv_r <= av_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a0_d2_r <= p1_w ? ed2_w[1] : ed2_w[0];
      a0_vx_r <= p1_w ? evx_w[1] : evx_w[0];
      a0_vy_r <= p1_w ? evy_w[1] : evy_w[0];
      a1_d2_r <= p3_w ? ed2_w[3] : ed2_w[2];
      a1_vx_r <= p3_w ? evx_w[3] : evx_w[2];
      a1_vy_r <= p3_w ? evy_w[3] : evy_w[2];
      ar_r    <= rline_r[EL-1];
      b_d2_r  <= pb_w ? a1_d2_r : a0_d2_r;
      b_vx_r  <= pb_w ? a1_vx_r : a0_vx_r;
      b_vy_r  <= pb_w ? a1_vy_r : a0_vy_r;
      br_r    <= ar_r;
    end
  end

  // ---- distance = floor(sqrt(d2))
  cqcp_pkg::pipe_ctl_t sq_ctl;
  logic                s_vld_w;
  logic [VW-1:0]       s_root_w;
  logic [SQ_SBW-1:0]   s_side_w;

  assign sq_ctl.en  = adv;
  assign sq_ctl.vld = bv_r;

  cqcp_sqrt #(
    .NW  (QW),
    .SBW (SQ_SBW)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sq_ctl),
    .radicand (b_d2_r),
    .side_i   ({b_vx_r, b_vy_r, br_r}),
    .vld_o    (s_vld_w),
    .root_o   (s_root_w),
    .side_o   (s_side_w)
  );

  // ---- hit test, magnitudes and signs
  logic signed [VW-1:0]   svx_w, svy_w;
  logic        [RADW-1:0] sr_w;
  logic                   c_vld_r, c_hit_r, c_nz_r, c_sx_r, c_sy_r;
  logic        [VW-1:0]   c_magx_r, c_magy_r, c_dist_r;
  logic        [RADW-1:0] c_diff_r;

  assign svx_w = s_side_w[SQ_SBW-1 -: VW];
  assign svy_w = s_side_w[SQ_SBW-1-VW -: VW];
  assign sr_w  = s_side_w[RADW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= s_vld_w;
    end
  end

  // diff is only meaningful on a hit; otherwise the result is masked
  always_ff @(posedge clk) begin
    if (adv) begin
      c_hit_r  <= s_root_w <= VW'(sr_w);
      c_nz_r   <= s_root_w != '0;
      c_sx_r   <= svx_w[VW-1];
      c_sy_r   <= svy_w[VW-1];
      c_magx_r <= svx_w[VW-1] ? unsigned'(-svx_w) : unsigned'(svx_w);
      c_magy_r <= svy_w[VW-1] ? unsigned'(-svy_w) : unsigned'(svy_w);
      c_diff_r <= RADW'(VW'(sr_w) - s_root_w);
      c_dist_r <= s_root_w;
    end
  end

  // ---- numerators |v| * (radius - dist)
  logic            d_vld_r, d_hit_r, d_nz_r, d_sx_r, d_sy_r;
  logic [NW-1:0]   d_numx_r, d_numy_r;
  logic [VW-1:0]   d_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (adv) begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_numx_r <= NW'(c_magx_r) * NW'(c_diff_r);
      d_numy_r <= NW'(c_magy_r) * NW'(c_diff_r);
      d_dist_r <= c_dist_r;
      d_hit_r  <= c_hit_r;
      d_nz_r   <= c_nz_r;
      d_sx_r   <= c_sx_r;
      d_sy_r   <= c_sy_r;
    end
  end

  // ---- push magnitudes, truncated toward zero
  cqcp_pkg::pipe_ctl_t dv_ctl;
  logic                x_vld_w;
  logic [CW-1:0]       x_quo_w, y_quo_w;
  logic [DX_SBW-1:0]   x_side_w;
  logic                y_side_w;

  assign dv_ctl.en  = adv;
  assign dv_ctl.vld = d_vld_r;

  cqcp_div #(
    .NW  (NW),
    .DVW (VW),
    .QB  (CW),
    .SBW (DX_SBW)
  ) u_div_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (dv_ctl),
    .num    (d_numx_r),
    .den    (d_dist_r),
    .side_i ({d_hit_r, d_nz_r, d_sx_r}),
    .vld_o  (x_vld_w),
    .quo    (x_quo_w),
    .side_o (x_side_w)
  );

  cqcp_div #(
    .NW  (NW),
    .DVW (VW),
    .QB  (CW),
    .SBW (1)
  ) u_div_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (dv_ctl),
    .num    (d_numy_r),
    .den    (d_dist_r),
    .side_i (d_sy_r),
    .vld_o  (),
    .quo    (y_quo_w),
    .side_o (y_side_w)
  );

  // ---- saturate, apply sign, mask misses and the zero-distance case
  logic          f_push_w;
  logic [CW-1:0] qx_w, qy_w;
  logic          hit_r;
  logic [CW-1:0] push_x_r, push_y_r;

  assign f_push_w = x_side_w[2] && x_side_w[1];
  assign qx_w     = (x_quo_w > MAXMAG) ? MAXMAG : x_quo_w;
  assign qy_w     = (y_quo_w > MAXMAG) ? MAXMAG : y_quo_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= x_vld_w;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r    <= x_side_w[2];
      push_x_r <= !f_push_w ? '0 : (x_side_w[0] ? -qx_w : qx_w);
      push_y_r <= !f_push_w ? '0 : (y_side_w ? -qy_w : qy_w);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'({push_y_r, push_x_r, hit_r});

endmodule

FILE: hdl/cqcp_checker.sv
// ----------------------------------------------------------------------------
// cqcp_checker
// Port-level checks of the collision pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cqcp_checker #(
  parameter int COORD_WIDTH = cqcp_pkg::COORD_WIDTH_DEF
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [((2*COORD_WIDTH+1+7)/8)*8-1:0] out_tdata
);

  localparam int CW = COORD_WIDTH;
  localparam logic [CW-1:0] MINNEG = {1'b1, {(CW-1){1'b0}}};

  // input side moves exactly when the output register can take a result
  `CQ_ASSERT_SAME(a_ready_flow, in_tvalid || !in_tvalid, in_tready == (!out_tvalid || out_tready), "in_tready does not follow the output stall")

  `CQ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed or dropped")

  // a miss never carries a push
  `CQ_ASSERT_SAME(a_miss_zero, out_tvalid && !out_tdata[0], out_tdata[2*CW:1] == '0, "push without hit")

  // saturation is symmetric, so the most negative code cannot appear
  `CQ_ASSERT_SAME(a_push_range, out_tvalid, (out_tdata[CW:1] != MINNEG) && (out_tdata[2*CW:CW+1] != MINNEG), "push outside the saturated range")

endmodule

bind circle_quad_collision_push cqcp_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_cqcp_checker (.*);

FILE: verif/circle_quad_collision_push_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circle_quad_collision_push_test
// Self-checking bench for the circle/quad collision pipeline. A directed table
// covers degenerate walls, extreme coordinates and edge ties. Random queries
// follow, mostly axis-aligned walls with the circle near an edge. Every query
// is predicted in wide integer arithmetic and compared with the pipeline
// output in order, under several idle and stall patterns.
// ----------------------------------------------------------------------------
module circle_quad_collision_push_test;

  localparam int IN_W     = 352;
  localparam int OUT_W    = 72;
  localparam int WD_LIMIT = 5000;
  localparam int HOLD_LEN = 400;

  typedef struct {
    logic signed [31:0] cx, cy;
    logic        [30:0] rad;
    logic signed [31:0] kx[4], ky[4];   // top_left, top_right, bottom_right, bottom_left
  } query_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] push_x, push_y;
  } push_t;

  typedef struct {
    query_t q;
    logic   known;   // expected result typed in below
    push_t  res;
  } table_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  push_t pending_pushes[$];
  int    error_count = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    hold_reqs = 0;
  int    hold_done = 0;
  int    hold_cnt = 0;
  int    quiet_cycles = 0;

  always #1 clk = ~clk;

  circle_quad_collision_push dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Closest-edge search, exact in 128-bit arithmetic.
  function automatic push_t predict_collision(query_t q);
    logic signed [127:0] sx, sy, lx, ly, px, py, dot, len2, t;
    logic signed [127:0] vx, vy, d2, best_d2, bx, by, v;
    logic        [127:0] near_len, cand, diff, m, quo;
    push_t res;
    best_d2 = 0; bx = 0; by = 0;
    for (int e = 0; e < 4; e++) begin
      sx = q.kx[e]; sy = q.ky[e];
      lx = q.kx[(e + 1) % 4]; lx = lx - sx;
      ly = q.ky[(e + 1) % 4]; ly = ly - sy;
      px = q.cx; px = px - sx;
      py = q.cy; py = py - sy;
      dot  = px * lx + py * ly;
      len2 = lx * lx + ly * ly;
      // clamp the edge parameter to [0, 1]; a zero-length edge lands on t = 0
      if (dot <= 0) t = 0;
      else if (dot >= len2) t = 128'sd65536;
      else t = (dot <<< 16) / len2;
      vx = px - ((lx * t) >>> 16);
      vy = py - ((ly * t) >>> 16);
      d2 = vx * vx + vy * vy;
      // strict compare keeps the earlier edge on a tie
      if (e == 0 || d2 < best_d2) begin
        best_d2 = d2; bx = vx; by = vy;
      end
    end
    near_len = 0;
    for (int b = 63; b >= 0; b--) begin
      cand = near_len | (128'd1 << b);
      if (cand * cand <= best_d2) near_len = cand;
    end
    res.hit = (near_len <= q.rad);
    res.push_x = '0;
    res.push_y = '0;
    if (res.hit && near_len != 0) begin
      diff = q.rad - near_len;
      for (int c = 0; c < 2; c++) begin
        v = (c == 0) ? bx : by;
        m = (v < 0) ? -v : v;
        quo = m * diff / near_len;
        if (quo > 128'h7FFF_FFFF) quo = 128'h7FFF_FFFF;
        if (v < 0) quo = -quo;
        if (c == 0) res.push_x = quo[31:0];
        else res.push_y = quo[31:0];
      end
    end
    return res;
  endfunction

  function automatic logic [IN_W-1:0] pack_query(query_t q);
    logic [IN_W-1:0] d;
    d = '0;
    d[31:0]  = q.cx;
    d[63:32] = q.cy;
    d[94:64] = q.rad;
    for (int i = 0; i < 4; i++) begin
      d[95 + 64*i +: 32]  = q.kx[i];
      d[127 + 64*i +: 32] = q.ky[i];
    end
    return d;
  endfunction

  function automatic logic signed [31:0] rand_coord(int span);
    return $signed($urandom_range(0, 2*span)) - span;
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int kind, base_x, base_y, w, h, jit, edge_sel;
    logic signed [31:0] ex, ey;
    kind = $urandom_range(0, 9);
    if (kind <= 1) begin
      // unconstrained noise: every bit of every field
      q.cx = $urandom; q.cy = $urandom; q.rad = $urandom;
      for (int i = 0; i < 4; i++) begin
        q.kx[i] = $urandom; q.ky[i] = $urandom;
      end
    end else if (kind == 9) begin
      // corners pinned to the range limits
      q.cx = $urandom; q.cy = $urandom; q.rad = $urandom;
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(0, 2))
          0: q.kx[i] = 32'sh8000_0000;
          1: q.kx[i] = 32'sh7FFF_FFFF;
          default: q.kx[i] = $urandom;
        endcase
        case ($urandom_range(0, 2))
          0: q.ky[i] = 32'sh8000_0000;
          1: q.ky[i] = 32'sh7FFF_FFFF;
          default: q.ky[i] = $urandom;
        endcase
      end
    end else begin
      // wall-like box with jittered corners, circle placed near one edge
      base_x = rand_coord(1 << 24);
      base_y = rand_coord(1 << 24);
      w = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 1 << 22);
      h = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 1 << 22);
      jit = $urandom_range(0, 1) ? 0 : (1 << 16);
      q.kx[0] = base_x + rand_coord(jit);     q.ky[0] = base_y + rand_coord(jit);
      q.kx[1] = base_x + w + rand_coord(jit); q.ky[1] = base_y + rand_coord(jit);
      q.kx[2] = base_x + w + rand_coord(jit); q.ky[2] = base_y + h + rand_coord(jit);
      q.kx[3] = base_x + rand_coord(jit);     q.ky[3] = base_y + h + rand_coord(jit);
      edge_sel = $urandom_range(0, 3);
      ex = q.kx[edge_sel] + (q.kx[(edge_sel + 1) % 4] - q.kx[edge_sel]) / 2;
      ey = q.ky[edge_sel] + (q.ky[(edge_sel + 1) % 4] - q.ky[edge_sel]) / 2;
      q.cx = ex + rand_coord(1 << $urandom_range(0, 22));
      q.cy = ey + rand_coord(1 << $urandom_range(0, 22));
      q.rad = $urandom_range(0, 1 << $urandom_range(0, 23));
    end
    return q;
  endfunction

  function automatic query_t make_query(int cx, int cy, int rad,
                                        int x0, int y0, int x1, int y1,
                                        int x2, int y2, int x3, int y3);
    query_t q;
    q.cx = cx; q.cy = cy; q.rad = rad;
    q.kx[0] = x0; q.ky[0] = y0; q.kx[1] = x1; q.ky[1] = y1;
    q.kx[2] = x2; q.ky[2] = y2; q.kx[3] = x3; q.ky[3] = y3;
    return q;
  endfunction

  // Offer one query starting at a falling edge; return at a falling edge
  // after the transaction is accepted. Record the prediction on acceptance.
  task automatic send_query(query_t q);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_query(q);
    do @(posedge clk); while (!in_tready);
    pending_pushes.push_back(predict_collision(q));
    @(negedge clk);
  endtask

  // Drive out_tready at falling edges; a hold request forces a long stall.
  always @(negedge clk) begin
    if (hold_cnt == 0 && hold_reqs != hold_done) begin
      hold_done = hold_done + 1;
      hold_cnt = HOLD_LEN;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    push_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pushes.size() == 0) begin
        $display("%0t: unexpected result hit=%0b push=(%h,%h)", $time,
                 out_tdata[0], out_tdata[32:1], out_tdata[64:33]);
        error_count++;
      end else begin
        want = pending_pushes.pop_front();
        if (out_tdata[0] !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, out_tdata[0]);
          error_count++;
        end
        if (out_tdata[32:1] !== want.push_x) begin
          $display("%0t: push_x expected %h actual %h", $time, want.push_x,
                   out_tdata[32:1]);
          error_count++;
        end
        if (out_tdata[64:33] !== want.push_y) begin
          $display("%0t: push_y expected %h actual %h", $time, want.push_y,
                   out_tdata[64:33]);
          error_count++;
        end
      end
    end
  end

  // Watchdog: give up after a long run with no transaction on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    table_row_t rows[$];
    table_row_t row;
    push_t      got;
    localparam int ONE = 65536;
    localparam int MAXI = 32'h7FFF_FFFF;
    localparam int MINI = 32'h8000_0000;

    // all corners and the center at the origin, zero radius: hit, no push
    row.q = make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    row.known = 1; row.res = '{1'b1, 32'd0, 32'd0}; rows.push_back(row);
    // degenerate wall far from the center: miss
    row.q = make_query(100*ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    row.known = 1; row.res = '{1'b0, 32'd0, 32'd0}; rows.push_back(row);
    row.known = 0;
    // 3-4-5 distance to a point wall, largest radius
    row.q = make_query(3*ONE, 4*ONE, MAXI, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
    // unit square, center just inside each edge
    row.q = make_query(ONE/2, ONE/8, ONE/4, 0, 0, ONE, 0, ONE, ONE, 0, ONE);
    rows.push_back(row);
    row.q = make_query(ONE-ONE/8, ONE/2, ONE/4, 0, 0, ONE, 0, ONE, ONE, 0, ONE);
    rows.push_back(row);
    row.q = make_query(ONE/2, ONE-ONE/8, ONE/4, 0, 0, ONE, 0, ONE, ONE, 0, ONE);
    rows.push_back(row);
    row.q = make_query(ONE/8, ONE/2, ONE/4, 0, 0, ONE, 0, ONE, ONE, 0, ONE);
    rows.push_back(row);
    // equal distance to top and right edges: tie goes to top
    row.q = make_query(ONE-ONE/4, ONE/4, ONE/2, 0, 0, ONE, 0, ONE, ONE, 0, ONE);
    rows.push_back(row);
    // center on the top edge: hit with zero distance
    row.q = make_query(ONE/2, 0, 5, 0, 0, ONE, 0, ONE, ONE, 0, ONE); rows.push_back(row);
    // outside near a corner, slanted wall
    row.q = make_query(-3*ONE, -3*ONE, 5*ONE, 0, 0, 4*ONE, ONE, 3*ONE, 5*ONE, -ONE, 3*ONE);
    rows.push_back(row);
    // extreme coordinates
    row.q = make_query(MAXI, MAXI, MAXI, MINI, MINI, MAXI, MINI, MAXI, MAXI, MINI, MAXI);
    rows.push_back(row);
    row.q = make_query(MINI, MAXI, MAXI, MAXI, MINI, MINI, MINI, MINI, MAXI, MAXI, MAXI);
    rows.push_back(row);
    row.q = make_query(MINI, MINI, 0, MAXI, MAXI, MAXI, MAXI, MAXI, MAXI, MAXI, MAXI);
    rows.push_back(row);
    row.q = make_query(0, 0, MAXI, MINI, MINI, MINI, MINI, MAXI, MAXI, MAXI, MAXI);
    rows.push_back(row);
    row.q = make_query(-1, -1, 1, 0, 0, 0, MAXI, MAXI, MAXI, MAXI, 0); rows.push_back(row);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table: typed-in results must agree with the predictor too
    foreach (rows[i]) begin
      if (rows[i].known) begin
        got = predict_collision(rows[i].q);
        if (got !== rows[i].res) begin
          $display("%0t: row %0d expected %p actual %p", $time, i, rows[i].res, got);
          error_count++;
        end
      end
      send_query(rows[i].q);
    end

    // random phases; the first one also holds off the receiver for long
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_reqs++; end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        3: begin send_idle_pct = 21; recv_stall_pct = 21; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      repeat (137) send_query(rand_query());
    end
    in_tvalid <= 1'b0;

    // drain, then allow for the pipeline latency
    while (pending_pushes.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
